/* hdl/wacrms_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wacrms_pkg
// Shared types and constants of the windowed AC RMS current meter.
// ----------------------------------------------------------------------------
package wacrms_pkg;

    localparam int MaxWindow  = 1024;
    localparam int SampleBits = 12;
    localparam int CntW       = $clog2(MaxWindow + 1);
    localparam int SumW       = SampleBits + CntW;
    localparam int SqW        = 2 * SampleBits + CntW;
    localparam int CfgIdxW    = 3;
    localparam int CfgDataW   = 20;

    localparam logic [CfgIdxW-1:0] CfgWindowLength = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgNoiseThresh  = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgCurrentScale = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgReportWin    = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgLineVoltage  = 3'd4;

    // One closed window, handed from the front to the back.
    typedef struct packed {
        logic [SampleBits-1:0] mn;
        logic [SampleBits-1:0] mx;
        logic [SumW-1:0]       sum;
        logic [SqW-1:0]        sq;
        logic [CntW-1:0]       n;
    } t_win;

endpackage
`default_nettype wire

/* hdl/wacrms_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wacrms_front
// Accumulates samples and closes windows into a small queue.
// ----------------------------------------------------------------------------
module wacrms_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [11:0]                         i_sample,
    input  wire logic [10:0]                         i_window_length,
    output logic                                     o_win_valid,
    input  wire logic                                i_win_ready,
    output wacrms_pkg::t_win                         o_win
);
    // Two-entry queue.
    wacrms_pkg::t_win r_q0, r_q1, n_q0, n_q1;
    logic [1:0] r_cnt, n_cnt;
    logic [wacrms_pkg::CntW-1:0] r_count, n_count;
    logic [wacrms_pkg::SampleBits-1:0] r_min, r_max, n_min, n_max;
    logic [wacrms_pkg::SumW-1:0] r_sum, n_sum;
    logic [wacrms_pkg::SqW-1:0]  r_sq, n_sq;
    logic [wacrms_pkg::CntW-1:0] w_len, w_cnt1;
    logic [wacrms_pkg::SampleBits-1:0] w_s, w_mn, w_mx;
    logic [2*wacrms_pkg::SampleBits-1:0] w_s2;
    logic w_acc, w_pop, w_close;
    wacrms_pkg::t_win w_new;

    assign o_ready     = (r_cnt != 2'd2);
    assign o_win_valid = (r_cnt != 2'd0);
    assign o_win       = r_q0;
    assign w_acc       = i_valid && o_ready;
    assign w_pop       = o_win_valid && i_win_ready;
    assign w_s         = i_sample;
    assign w_s2        = w_s * w_s;

    always_comb begin
        if (i_window_length == 11'd0) begin
            w_len = 11'd1;
        end else if (i_window_length > 11'(wacrms_pkg::MaxWindow)) begin
            w_len = 11'(wacrms_pkg::MaxWindow);
        end else begin
            w_len = i_window_length;
        end
        w_cnt1  = r_count + 11'd1;
        w_mn    = (w_s < r_min) ? w_s : r_min;
        w_mx    = (w_s > r_max) ? w_s : r_max;
        w_close = (w_cnt1 >= w_len);
        w_new.mn  = w_mn;
        w_new.mx  = w_mx;
        w_new.sum = r_sum + wacrms_pkg::SumW'(w_s);
        w_new.sq  = r_sq + wacrms_pkg::SqW'(w_s2);
        w_new.n   = w_cnt1;

        n_count = r_count;
        n_min = r_min;
        n_max = r_max;
        n_sum = r_sum;
        n_sq  = r_sq;
        n_q0 = r_q0;
        n_q1 = r_q1;
        n_cnt = r_cnt;
        if (w_acc) begin
            if (w_close) begin
                n_count = '0;
                n_min = '1;
                n_max = '0;
                n_sum = '0;
                n_sq  = '0;
            end else begin
                n_count = w_cnt1;
                n_min = w_mn;
                n_max = w_mx;
                n_sum = w_new.sum;
                n_sq  = w_new.sq;
            end
        end
        if (w_pop) begin
            n_q0  = r_q1;
            n_cnt = r_cnt - 2'd1;
        end
        if (w_acc && w_close) begin
            if (n_cnt == 2'd0) begin
                n_q0 = w_new;
            end else begin
                n_q1 = w_new;
            end
            n_cnt = n_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_count <= '0;
            r_min   <= '1;
            r_max   <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
        end else begin
            r_cnt   <= n_cnt;
            r_count <= n_count;
            r_min   <= n_min;
            r_max   <= n_max;
            r_sum   <= n_sum;
            r_sq    <= n_sq;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end
endmodule
`default_nettype wire

/* hdl/wacrms_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wacrms_back
// Sequencer that turns a closed window into the RMS, current and report.
// ----------------------------------------------------------------------------
module wacrms_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_win_valid,
    output logic                    o_win_ready,
    input  wire wacrms_pkg::t_win   i_win,
    input  wire logic [14:0]        i_noise_threshold_q4,
    input  wire logic [19:0]        i_current_scale,
    input  wire logic [7:0]         i_report_windows,
    input  wire logic [8:0]         i_line_voltage,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [11:0]             o_window_min,
    output logic [11:0]             o_window_max,
    output logic [11:0]             o_peak_to_peak,
    output logic [15:0]             o_mean_q4,
    output logic [14:0]             o_rms_q4,
    output logic [15:0]             o_current_ma,
    output logic                    o_report_valid,
    output logic [15:0]             o_average_current_ma,
    output logic [24:0]             o_apparent_power_mva
);
    // Widths: N*sumsq < 2^(35+11); shifted numerator < 2^54; n^2 < 2^21.
    localparam int NumW = wacrms_pkg::SqW + wacrms_pkg::CntW + 8;
    localparam int NnW  = 2 * wacrms_pkg::CntW;
    localparam int MnW  = wacrms_pkg::SumW + 4;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_DIV, S_SQRT, S_CUR, S_ACC, S_AVG, S_PWR, S_OUT
    } t_state;

    t_state r_state;
    wacrms_pkg::t_win r_win;
    logic [NumW-1:0] r_num;      // dividend / remainder
    logic [NumW-1:0] r_quo;
    logic [NnW-1:0]  r_den;
    logic [MnW-1:0]  r_mrem;     // mean division
    logic [15:0]     r_mquo;
    logic [5:0]      r_step;
    logic [NumW-1:0] r_sqv;      // sqrt remainder
    logic [27:0]     r_root;
    logic [35:0]     r_cur;
    logic [23:0]     r_csum;
    logic [7:0]      r_wcnt;
    logic [23:0]     r_arem;
    logic [15:0]     r_aquo;
    logic            r_rep;
    logic [NumW-1:0] r_prod;

    logic [NumW-1:0]  w_trial;
    logic [NumW:0]    w_sq_try;
    logic [MnW-1:0]   w_mtrial;
    logic [23:0]      w_atrial;
    logic [14:0]      w_rms;
    logic [15:0]      w_cur;
    logic [7:0]       w_reps;
    logic [23:0]      w_csum_n;
    logic [7:0]       w_wcnt_n;

    assign o_win_ready = (r_state == S_IDLE);
    assign w_trial  = r_num >> r_step;
    assign w_mtrial = r_mrem >> r_step[3:0];
    assign w_atrial = r_arem >> r_step[3:0];
    assign w_sq_try = {1'b0, r_sqv} - {1'b0, (NumW'(r_root) << 2 | NumW'(1)) << {r_step, 1'b0}};
    assign w_rms    = (r_root > 28'd32767) ? 15'd32767 : r_root[14:0];
    assign w_cur    = (r_cur[35:32] != 4'd0) ? 16'hFFFF : r_cur[31:16];
    assign w_reps   = (i_report_windows == 8'd0) ? 8'd1 : i_report_windows;
    assign w_csum_n = r_csum + 24'(o_current_ma);
    assign w_wcnt_n = r_wcnt + 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_csum  <= '0;
            r_wcnt  <= '0;
            r_rep   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_win_valid) begin
                        r_win   <= i_win;
                        r_prod  <= NumW'(i_win.n) * NumW'(i_win.sq);
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    // Variance numerator, then the Q8 shift.
                    if (r_prod > NumW'(r_win.sum) * NumW'(r_win.sum)) begin
                        r_num <= (r_prod - NumW'(r_win.sum) * NumW'(r_win.sum)) << 8;
                    end else begin
                        r_num <= '0;
                    end
                    r_den   <= NnW'(r_win.n) * NnW'(r_win.n);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_quo   <= '0;
                    r_mrem  <= {r_win.sum, 4'd0};
                    r_mquo  <= '0;
                    r_step  <= 6'(NumW - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // Restoring division, one quotient bit a cycle; the mean
                    // division runs beside it over its last 16 steps.
                    if (w_trial >= NumW'(r_den)) begin
                        r_num <= r_num - (NumW'(r_den) << r_step);
                        r_quo[r_step] <= 1'b1;
                    end
                    if (r_step < 6'd16) begin
                        if (w_mtrial >= MnW'(r_win.n)) begin
                            r_mrem <= r_mrem - (MnW'(r_win.n) << r_step[3:0]);
                            r_mquo[r_step[3:0]] <= 1'b1;
                        end
                    end
                    if (r_step == 6'd0) begin
                        r_state <= S_SQRT;
                        r_step  <= 6'd27;
                        r_root  <= '0;
                    end else begin
                        r_step <= r_step - 6'd1;
                    end
                end
                S_SQRT: begin
                    // Digit-by-digit square root, one result bit a cycle. The
                    // first cycle only loads the quotient as the remainder.
                    if (r_step == 6'd27) begin
                        r_sqv  <= r_quo;
                        r_step <= 6'd26;
                    end else begin
                        if (!w_sq_try[NumW]) begin
                            r_sqv  <= w_sq_try[NumW-1:0];
                            r_root <= (r_root << 1) | 28'd1;
                        end else begin
                            r_root <= r_root << 1;
                        end
                        if (r_step == 6'd0) begin
                            r_state <= S_CUR;
                        end else begin
                            r_step <= r_step - 6'd1;
                        end
                    end
                end
                S_CUR: begin
                    r_cur   <= 36'(w_rms) * 36'(i_current_scale);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    o_window_min   <= r_win.mn;
                    o_window_max   <= r_win.mx;
                    o_peak_to_peak <= r_win.mx - r_win.mn;
                    o_mean_q4      <= r_mquo;
                    o_rms_q4       <= w_rms;
                    o_current_ma   <= (w_rms < i_noise_threshold_q4) ? 16'd0 : w_cur;
                    r_state        <= S_AVG;
                    r_step         <= 6'd15;
                    r_aquo         <= '0;
                end
                S_AVG: begin
                    if (r_step == 6'd15 && r_aquo == 16'd0 && !r_rep) begin
                        r_rep  <= (w_wcnt_n >= w_reps);
                        r_arem <= w_csum_n;
                        r_csum <= w_csum_n;
                        r_wcnt <= w_wcnt_n;
                        if (w_wcnt_n < w_reps) begin
                            r_state <= S_PWR;
                        end
                    end else begin
                        // Average: quotient saturates at 16 bits.
                        if (r_arem[23:16] >= r_wcnt) begin
                            r_aquo  <= 16'hFFFF;
                            r_step  <= 6'd0;
                            r_arem  <= '0;
                        end else if (w_atrial >= 24'(r_wcnt)) begin
                            r_arem <= r_arem - (24'(r_wcnt) << r_step[3:0]);
                            r_aquo[r_step[3:0]] <= 1'b1;
                        end
                        if (r_step == 6'd0 || r_arem[23:16] >= r_wcnt) begin
                            r_state <= S_PWR;
                        end else begin
                            r_step <= r_step - 6'd1;
                        end
                    end
                end
                S_PWR: begin
                    o_report_valid <= r_rep;
                    if (r_rep) begin
                        o_average_current_ma <= r_aquo;
                        o_apparent_power_mva <= 25'(r_aquo) * 25'(i_line_voltage);
                        r_csum <= '0;
                        r_wcnt <= '0;
                    end else begin
                        o_average_current_ma <= '0;
                        o_apparent_power_mva <= '0;
                    end
                    r_rep   <= 1'b0;
                    o_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_IDLE) begin
                r_rep <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

/* hdl/windowed_ac_rms_current_meter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_ac_rms_current_meter_unit
// Windowed min/max/mean/AC RMS meter with current and power reports.
// ----------------------------------------------------------------------------
// Samples enter on the i_valid/o_ready channel, one item per cycle. The front
// end accumulates min, max, sum and sum of squares and closes a window on its
// last sample, pushing it into a two-entry queue. The back end is a
// sequencer: a variance multiply, a 54-step restoring divider (the mean
// divides alongside it), a square root, a current multiply and a 16-step
// report divider. Windows longer than this sequence keep full sample rate;
// shorter windows make the front stall when the queue fills. One result
// item per window appears on o_valid/i_ready and is held until taken; while
// it waits the front still accepts samples until its queue fills. Reset
// clears the accumulators, queue, report counters and loads the register
// defaults. Configuration writes take effect at once; the user makes them
// only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module windowed_ac_rms_current_meter_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [11:0] i_sample,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [19:0] i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [11:0]      o_window_min,
    output logic [11:0]      o_window_max,
    output logic [11:0]      o_peak_to_peak,
    output logic [15:0]      o_mean_q4,
    output logic [14:0]      o_rms_q4,
    output logic [15:0]      o_current_ma,
    output logic             o_report_valid,
    output logic [15:0]      o_average_current_ma,
    output logic [24:0]      o_apparent_power_mva
);
    logic [10:0] r_window_length;
    logic [14:0] r_noise;
    logic [19:0] r_scale;
    logic [7:0]  r_reps;
    logic [8:0]  r_volt;
    logic        w_win_valid, w_win_ready;
    wacrms_pkg::t_win w_win;

    // Register file; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= 11'd500;
            r_noise         <= 15'd595;
            r_scale         <= 20'd99027;
            r_reps          <= 8'd15;
            r_volt          <= 9'd127;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wacrms_pkg::CfgWindowLength: r_window_length <= i_cfg_data[10:0];
                wacrms_pkg::CfgNoiseThresh:  r_noise         <= i_cfg_data[14:0];
                wacrms_pkg::CfgCurrentScale: r_scale         <= i_cfg_data;
                wacrms_pkg::CfgReportWin:    r_reps          <= i_cfg_data[7:0];
                wacrms_pkg::CfgLineVoltage:  r_volt          <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    wacrms_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample        (i_sample),
        .i_window_length (r_window_length),
        .o_win_valid     (w_win_valid),
        .i_win_ready     (w_win_ready),
        .o_win           (w_win)
    );

    wacrms_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_win_valid          (w_win_valid),
        .o_win_ready          (w_win_ready),
        .i_win                (w_win),
        .i_noise_threshold_q4 (r_noise),
        .i_current_scale      (r_scale),
        .i_report_windows     (r_reps),
        .i_line_voltage       (r_volt),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_window_min         (o_window_min),
        .o_window_max         (o_window_max),
        .o_peak_to_peak       (o_peak_to_peak),
        .o_mean_q4            (o_mean_q4),
        .o_rms_q4             (o_rms_q4),
        .o_current_ma         (o_current_ma),
        .o_report_valid       (o_report_valid),
        .o_average_current_ma (o_average_current_ma),
        .o_apparent_power_mva (o_apparent_power_mva)
    );

    // The RMS field of a result is held while the receiver stalls.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rms_q4))
        else $error("result changed while stalled");

    // The peak-to-peak field agrees with min and max.
    a_p2p: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_peak_to_peak == o_window_max - o_window_min)
        else $error("peak-to-peak mismatch");

    // The average current field is zero without a report.
    a_rep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_report_valid |-> o_average_current_ma == 16'd0)
        else $error("stale average");
endmodule
`default_nettype wire

/* dv/tb_windowed_ac_rms_current_meter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_ac_rms_current_meter_unit
// Self-checking bench for the windowed AC RMS current meter.
// ----------------------------------------------------------------------------
// A short table of directed samples and register writes runs first, then a set
// of register phases with random sample streams. Every accepted sample is fed
// to a local window model; each window it closes queues one expected result,
// and every result taken from the block is compared field by field against the
// oldest one. Both handshake sides insert random gaps, except in quiet phases.
// ----------------------------------------------------------------------------
module tb_windowed_ac_rms_current_meter_unit;

    localparam int WatchdogLimit = 5000;
    localparam int SettleCycles  = 150;

    // One result item of the block.
    typedef struct {
        logic [11:0] mn;
        logic [11:0] mx;
        logic [11:0] p2p;
        logic [15:0] mean;
        logic [14:0] rms;
        logic [15:0] cur;
        logic        rv;
        logic [15:0] avg;
        logic [24:0] pwr;
    } t_window_result;

    typedef enum logic {RowSample, RowWrite} t_row_kind;

    // A directed row is either a register write or a sample. A sample row
    // marked known carries a window of one sample, whose statistics are
    // obvious: min and max equal the sample, the mean is the sample in Q4 and
    // the RMS is zero.
    typedef struct {
        t_row_kind                      kind;
        logic [wacrms_pkg::CfgIdxW-1:0] idx;
        logic [19:0]                    val;
        bit                             known;
    } t_stim_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [11:0]       i_sample;
    logic              i_cfg_we;
    logic [2:0]        i_cfg_index;
    logic [19:0]       i_cfg_data;
    logic              o_valid;
    logic              i_ready;
    logic [11:0]       o_window_min;
    logic [11:0]       o_window_max;
    logic [11:0]       o_peak_to_peak;
    logic [15:0]       o_mean_q4;
    logic [14:0]       o_rms_q4;
    logic [15:0]       o_current_ma;
    logic              o_report_valid;
    logic [15:0]       o_average_current_ma;
    logic [24:0]       o_apparent_power_mva;

    windowed_ac_rms_current_meter_unit DUT (.*);

    // Register copies and window state of the local model.
    logic [10:0] m_window_len;
    logic [14:0] m_noise_thresh;
    logic [19:0] m_scale;
    logic [7:0]  m_report_win;
    logic [8:0]  m_volts;
    longint unsigned m_count, m_min, m_max, m_sum, m_sqsum, m_win_count, m_cur_sum;

    t_window_result pending_windows[$];
    int  errors;
    int  idle_cycles;
    bit  tx_no_gap;
    bit  rx_no_stall;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= root + b) begin
                v -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    function void clear_window_state();
        m_count = 0;
        m_min   = 4095;
        m_max   = 0;
        m_sum   = 0;
        m_sqsum = 0;
    endfunction

    // Accumulates one sample; returns 1 and fills r when the window closes.
    function bit accumulate_sample(input logic [11:0] s, output t_window_result r);
        longint unsigned len, n, sq, var_num, rms, cur, avg, pwr, reps;
        avg = 0;
        pwr = 0;
        r.rv = 1'b0;
        len = m_window_len;
        if (len == 0) len = 1;
        if (len > wacrms_pkg::MaxWindow) len = wacrms_pkg::MaxWindow;
        m_count++;
        if (s < m_min) m_min = s;
        if (s > m_max) m_max = s;
        m_sum   += s;
        m_sqsum += longint'(s) * s;
        if (m_count < len) return 1'b0;

        n       = m_count;
        sq      = m_sum * m_sum;
        var_num = n * m_sqsum;
        var_num = (var_num > sq) ? var_num - sq : 0;
        rms     = int_sqrt((var_num << 8) / (n * n));
        if (rms > 32767) rms = 32767;
        // Below the noise floor the current is forced to zero.
        if (rms < m_noise_thresh) begin
            cur = 0;
        end else begin
            cur = (rms * m_scale) >> 16;
            if (cur > 65535) cur = 65535;
        end
        r.mn   = m_min[11:0];
        r.mx   = m_max[11:0];
        r.p2p  = 12'(m_max - m_min);
        r.mean = 16'((m_sum << 4) / n);
        r.rms  = rms[14:0];
        r.cur  = cur[15:0];

        m_cur_sum   = (m_cur_sum + cur) & 24'hFFFFFF;
        m_win_count = (m_win_count + 1) & 8'hFF;
        reps = (m_report_win == 0) ? 1 : m_report_win;
        if (m_win_count >= reps) begin
            avg = m_cur_sum / m_win_count;
            if (avg > 65535) avg = 65535;
            pwr = avg * m_volts;
            r.rv = 1'b1;
            m_win_count = 0;
            m_cur_sum   = 0;
        end
        r.avg = avg[15:0];
        r.pwr = pwr[24:0];
        clear_window_state();
        return 1'b1;
    endfunction

    // Writes a register only once the block has drained: every result is in,
    // and the back end has had time to finish anything still in flight.
    task automatic write_reg(input logic [wacrms_pkg::CfgIdxW-1:0] idx,
                             input logic [19:0] val);
        i_valid = 1'b0;
        while (pending_windows.size() != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            wacrms_pkg::CfgWindowLength: m_window_len   = val[10:0];
            wacrms_pkg::CfgNoiseThresh:  m_noise_thresh = val[14:0];
            wacrms_pkg::CfgCurrentScale: m_scale        = val[19:0];
            wacrms_pkg::CfgReportWin:    m_report_win   = val[7:0];
            wacrms_pkg::CfgLineVoltage:  m_volts        = val[8:0];
            default: ;
        endcase
    endtask

    // Presents one sample, waits for it to be taken and records what it
    // should produce. Called and returns at a falling edge.
    task automatic send_sample(input logic [11:0] s, input bit known);
        int gap;
        t_window_result r;
        gap = tx_no_gap ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  = 1'b1;
        i_sample = s;
        forever begin
            @(posedge i_clk);
            if (o_ready) break;
        end
        if (accumulate_sample(s, r)) begin
            if (known) begin
                r.mn   = s;
                r.mx   = s;
                r.p2p  = '0;
                r.mean = {s, 4'h0};
                r.rms  = '0;
                r.cur  = '0;
            end
            pending_windows.push_back(r);
        end
        @(negedge i_clk);
    endtask

    function automatic logic [11:0] pick_sample(input int style, input int centre);
        int v;
        case (style)
            0: v = $urandom_range(0, 4095);
            1: v = ($urandom_range(0, 1) != 0) ? 4095 : 0;
            2: v = centre + $urandom_range(0, 200) - 100;
            default: v = 2048 + $urandom_range(0, 2000) - 1000;
        endcase
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v[11:0];
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Result checker: compares each taken result with the oldest expectation.
    always @(posedge i_clk) begin
        t_window_result e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_windows.size() == 0) begin
                $display("%0t ns: unexpected result item, expected none, actual min %0d",
                         $time, o_window_min);
                errors++;
            end else begin
                e = pending_windows.pop_front();
                check_field("window_min", e.mn, o_window_min);
                check_field("window_max", e.mx, o_window_max);
                check_field("peak_to_peak", e.p2p, o_peak_to_peak);
                check_field("mean_q4", e.mean, o_mean_q4);
                check_field("rms_q4", e.rms, o_rms_q4);
                check_field("current_ma", e.cur, o_current_ma);
                check_field("report_valid", e.rv, o_report_valid);
                check_field("average_current_ma", e.avg, o_average_current_ma);
                check_field("apparent_power_mva", e.pwr, o_apparent_power_mva);
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Result side: random stalls before each item, none in quiet phases.
    initial begin
        int k;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            k = rx_no_stall ? 0 : $urandom_range(0, 13);
            if (k != 0) begin
                i_ready = 1'b0;
                repeat (k) @(negedge i_clk);
            end
            i_ready = 1'b1;
            forever begin
                @(posedge i_clk);
                if (o_valid) break;
            end
            @(negedge i_clk);
        end
    end

    initial begin
        t_stim_row rows[$];
        int wl, thr, scl, rep, vlt, nsamp, style, centre;

        errors      = 0;
        idle_cycles = 0;
        tx_no_gap   = 1'b0;
        rx_no_stall = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_sample    = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;

        m_window_len   = 500;
        m_noise_thresh = 595;
        m_scale        = 99027;
        m_report_win   = 15;
        m_volts        = 127;
        clear_window_state();
        m_win_count = 0;
        m_cur_sum   = 0;

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: single-sample windows at the sample extremes, then
        // the widest possible swing with full-scale current and power, then
        // zero length and zero report count, both of which act as one.
        rows = '{
            '{RowWrite,  wacrms_pkg::CfgWindowLength, 20'd1,     1'b0},
            '{RowSample, '0,                          20'd0,     1'b1},
            '{RowSample, '0,                          20'd4095,  1'b1},
            '{RowSample, '0,                          20'd1,     1'b1},
            '{RowSample, '0,                          20'd2048,  1'b1},
            '{RowSample, '0,                          20'd2047,  1'b1},
            '{RowSample, '0,                          20'hAAA,   1'b1},
            '{RowSample, '0,                          20'h555,   1'b1},
            '{RowWrite,  wacrms_pkg::CfgReportWin,    20'd0,     1'b0},
            '{RowWrite,  wacrms_pkg::CfgLineVoltage,  20'd511,   1'b0},
            '{RowWrite,  wacrms_pkg::CfgNoiseThresh,  20'd0,     1'b0},
            '{RowWrite,  wacrms_pkg::CfgCurrentScale, 20'hFFFFF, 1'b0},
            '{RowWrite,  wacrms_pkg::CfgWindowLength, 20'd2,     1'b0},
            '{RowSample, '0,                          20'd0,     1'b0},
            '{RowSample, '0,                          20'd4095,  1'b0},
            '{RowSample, '0,                          20'd4095,  1'b0},
            '{RowSample, '0,                          20'd4095,  1'b0},
            '{RowWrite,  wacrms_pkg::CfgWindowLength, 20'd0,     1'b0},
            '{RowSample, '0,                          20'd123,   1'b1},
            '{RowSample, '0,                          20'd4000,  1'b1}
        };
        foreach (rows[i]) begin
            if (rows[i].kind == RowWrite)
                write_reg(rows[i].idx, rows[i].val);
            else
                send_sample(rows[i].val[11:0], rows[i].known);
        end

        // Random phases. The first four pin the register extremes: the
        // saturated window length, a long report at full scale, a threshold
        // no RMS can reach and a zero scale. The rest draw short windows and
        // random settings. Each phase starts on whatever partial window the
        // last one left, so a shorter length closes it on the next sample.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin wl = 2047; thr = 595;   scl = 99027;   rep = 1;  vlt = 127; nsamp = 1030; end
                1: begin wl = 1;    thr = 0;     scl = 1048575; rep = 40; vlt = 511; nsamp = 60;   end
                2: begin wl = 8;    thr = 32767; scl = 99027;   rep = 3;  vlt = 0;   nsamp = 40;   end
                3: begin wl = 5;    thr = 0;     scl = 0;       rep = 2;  vlt = 300; nsamp = 30;   end
                default: begin
                    wl    = $urandom_range(1, 12);
                    thr   = $urandom_range(0, 3000);
                    scl   = $urandom_range(0, 1048575);
                    rep   = $urandom_range(1, 6);
                    vlt   = $urandom_range(0, 511);
                    nsamp = 25;
                end
            endcase
            write_reg(wacrms_pkg::CfgWindowLength, 20'(wl));
            write_reg(wacrms_pkg::CfgNoiseThresh,  20'(thr));
            write_reg(wacrms_pkg::CfgCurrentScale, 20'(scl));
            write_reg(wacrms_pkg::CfgReportWin,    20'(rep));
            write_reg(wacrms_pkg::CfgLineVoltage,  20'(vlt));
            tx_no_gap   = (ph % 3 == 1);
            rx_no_stall = (ph % 4 == 2);
            style  = $urandom_range(0, 3);
            centre = $urandom_range(0, 4095);
            for (int k = 0; k < nsamp; k++) begin
                if ($urandom_range(0, 15) == 0) style = $urandom_range(0, 3);
                send_sample(pick_sample(style, centre), 1'b0);
            end
        end

        i_valid = 1'b0;
        while (pending_windows.size() != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
